/* src/prp_pkg.sv */
// ----------------------------------------------------------------------------
// prp_pkg: shared types and constants of the point rotate and project block
// Field widths, intermediate widths of the datapath, register indexes,
// register reset values and the bundles that travel between the units.
// ----------------------------------------------------------------------------
`default_nettype none

package prp_pkg;

   // Widths of the external fields.
   localparam int TRIG_W     = 10;
   localparam int COORD_W    = 16;
   localparam int HALF_W     = COORD_W - 1;
   localparam int FOCAL_W    = 15;
   localparam int SCALE_W    = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Widths inside the datapath, sized to the largest reachable magnitudes.
   localparam int P1_W  = TRIG_W + HALF_W;   // pitch products
   localparam int S1_W  = P1_W + 1;          // pitch sums
   localparam int X1_W  = 18;                // pitch-rotated x, up to 2^16
   localparam int Z2_W  = 18;                // rotated depth, up to 2^17
   localparam int P2_W  = TRIG_W + X1_W;     // yaw products and sums
   localparam int X2_W  = 20;                // yaw-rotated x and y, below 2^19
   localparam int MAG_W = X2_W - 1;          // magnitude of x2 or y2
   localparam int DVD_W = MAG_W + FOCAL_W;   // perspective dividend
   localparam int DVS_W = Z2_W - 1;          // positive depth as divisor

   // Divider: quotient bits resolved per stage and number of stages.
   localparam int DIV_BITS   = 2;
   localparam int DIV_STAGES = (DVD_W + DIV_BITS - 1) / DIV_BITS;

   // Clock edges from an accepted start to the result strobe being sampled.
   localparam int LATENCY = DIV_STAGES + 7;

   typedef logic signed [TRIG_W-1:0]  trig_type;
   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic        [FOCAL_W-1:0] focal_type;
   typedef logic        [SCALE_W-1:0] scale_type;
   typedef logic signed [X2_W-1:0]    x2_type;
   typedef logic signed [Z2_W-1:0]    z2_type;
   typedef logic [CSR_IDX_W-1:0]      csr_idx_type;
   typedef logic [CSR_DATA_W-1:0]     csr_data_type;

   // Register indexes.
   localparam csr_idx_type CSR_COS_PITCH      = 3'd0;
   localparam csr_idx_type CSR_SIN_PITCH      = 3'd1;
   localparam csr_idx_type CSR_COS_YAW        = 3'd2;
   localparam csr_idx_type CSR_SIN_YAW        = 3'd3;
   localparam csr_idx_type CSR_CENTER_X       = 3'd4;
   localparam csr_idx_type CSR_CENTER_Y       = 3'd5;
   localparam csr_idx_type CSR_FOCAL_DISTANCE = 3'd6;

   // Screen x reported for a point that is not in front of the viewer.
   localparam coord_type HIDDEN_X  = -16'sd256;
   localparam scale_type SCALE_MAX = 4'd15;

   typedef struct packed {
      trig_type  cos_pitch;
      trig_type  sin_pitch;
      trig_type  cos_yaw;
      trig_type  sin_yaw;
      coord_type center_x;
      coord_type center_y;
      focal_type focal_distance;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      cos_pitch:      10'sd256,
      sin_pitch:      10'sd0,
      cos_yaw:        10'sd256,
      sin_yaw:        10'sd0,
      center_x:       16'sd128,
      center_y:       16'sd96,
      focal_distance: 15'd128
   };

   // Rotated point handed from the rotation pipeline to the projection.
   typedef struct packed {
      logic      valid;
      x2_type    x2;
      x2_type    y2;
      z2_type    z2;
      logic      visible;
      scale_type scale;
   } rot_type;

   // Finished result.
   typedef struct packed {
      logic      valid;
      coord_type screen_x;
      coord_type screen_y;
      logic      visible;
      scale_type depth_scale;
   } rsp_type;

endpackage

`default_nettype wire

/* src/point_rotate_project.sv */
// ----------------------------------------------------------------------------
// point_rotate_project: 3D point rotation and perspective projection
// Halves a world point, rotates it about pitch and yaw, and projects it onto
// the screen with a depth scale index.
// ----------------------------------------------------------------------------
// A point is taken on every clock edge where start is high and busy is low,
// and its result appears on the rsp_ ports as a one-cycle strobe on
// rsp_valid; results come out in order at up to one per cycle.
// Points pass through seven arithmetic and register stages and the 17-stage
// pipelined dividers that do the perspective divide, two quotient bits per
// stage. The receiver cannot stall the block, so it must take every strobe.
// Busy is high during reset and in the cycle after it, and low from then
// on. Register writes through the csr_ port are accepted in every cycle and
// must be made while no point is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module point_rotate_project (
   input  logic                   clock,
   input  logic                   reset,
   // Point transactions
   input  logic                   start,
   output logic                   busy,
   input  prp_pkg::coord_type     req_pos_x,
   input  prp_pkg::coord_type     req_pos_y,
   input  prp_pkg::coord_type     req_pos_z,
   // Result transactions
   output logic                   rsp_valid,
   output prp_pkg::coord_type     rsp_screen_x,
   output prp_pkg::coord_type     rsp_screen_y,
   output logic                   rsp_visible,
   output prp_pkg::scale_type     rsp_depth_scale,
   // Register write transactions
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  prp_pkg::csr_idx_type   csr_index,
   input  prp_pkg::csr_data_type  csr_wdata
);
   import prp_pkg::*;

   logic    busy_ff, busy_in;
   logic    accept;
   cfg_type cfg;
   rot_type rot;
   rsp_type rsp;

   // Busy holds off points during reset and in the cycle after it.
   always_comb begin
      busy_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign busy   = busy_ff;
   assign accept = start & ~busy_ff;

   prp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   prp_rotate u_rotate (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .pos_x    (req_pos_x),
      .pos_y    (req_pos_y),
      .pos_z    (req_pos_z),
      .cfg      (cfg),
      .rot      (rot)
   );

   prp_project u_project (
      .clock (clock),
      .reset (reset),
      .rot   (rot),
      .cfg   (cfg),
      .rsp   (rsp)
   );

   // Result ports.
   assign rsp_valid       = rsp.valid;
   assign rsp_screen_x    = rsp.screen_x;
   assign rsp_screen_y    = rsp.screen_y;
   assign rsp_visible     = rsp.visible;
   assign rsp_depth_scale = rsp.depth_scale;

endmodule

`default_nettype wire

/* src/prp_csr.sv */
// ----------------------------------------------------------------------------
// prp_csr: configuration registers
// Holds the trigonometric factors, screen center and focal distance. Writes
// to an index outside the register list are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module prp_csr (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  prp_pkg::csr_idx_type   csr_index,
   input  prp_pkg::csr_data_type  csr_wdata,
   output prp_pkg::cfg_type       cfg
);
   import prp_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // The register file can take a write transaction in every cycle.
   assign csr_ready = 1'b1;

   // Write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_COS_PITCH:      cfg_in.cos_pitch      = csr_wdata[TRIG_W-1:0];
            CSR_SIN_PITCH:      cfg_in.sin_pitch      = csr_wdata[TRIG_W-1:0];
            CSR_COS_YAW:        cfg_in.cos_yaw        = csr_wdata[TRIG_W-1:0];
            CSR_SIN_YAW:        cfg_in.sin_yaw        = csr_wdata[TRIG_W-1:0];
            CSR_CENTER_X:       cfg_in.center_x       = csr_wdata;
            CSR_CENTER_Y:       cfg_in.center_y       = csr_wdata;
            CSR_FOCAL_DISTANCE: cfg_in.focal_distance = csr_wdata[FOCAL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

/* src/prp_rotate.sv */
// ----------------------------------------------------------------------------
// prp_rotate: halving and pitch/yaw rotation pipeline
// Five register stages: halve the input, pitch products, pitch sums, yaw
// products, yaw sums with the visibility test and depth scale index.
// ----------------------------------------------------------------------------
`default_nettype none

module prp_rotate (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  prp_pkg::coord_type  pos_x,
   input  prp_pkg::coord_type  pos_y,
   input  prp_pkg::coord_type  pos_z,
   input  prp_pkg::cfg_type    cfg,
   output prp_pkg::rot_type    rot
);
   import prp_pkg::*;

   localparam int DIFF_W      = Z2_W + 1;
   localparam int SCALE_SHIFT = 3;

   localparam logic signed [S1_W-1:0] BIAS1_8 = S1_W'(255);
   localparam logic signed [S1_W-1:0] BIAS1_7 = S1_W'(127);
   localparam logic signed [S1_W-1:0] ZERO1   = S1_W'(0);
   localparam logic signed [P2_W-1:0] BIAS2_7 = P2_W'(127);
   localparam logic signed [P2_W-1:0] ZERO2   = P2_W'(0);

   // Halve toward zero: add one to negative values before the shift.
   function automatic logic signed [HALF_W-1:0] half_coord(input coord_type v);
      logic signed [COORD_W-1:0] biased;
      biased = v + $signed({{(COORD_W-1){1'b0}}, v[COORD_W-1]});
      return HALF_W'(biased >>> 1);
   endfunction

   // Stage 0: halved coordinates.
   logic                     s0_valid_ff, s0_valid_in;
   logic signed [HALF_W-1:0] s0_x_ff, s0_y_ff, s0_z_ff;
   logic signed [HALF_W-1:0] s0_x_in, s0_y_in, s0_z_in;

   // Stage 1: pitch products.
   logic                     s1_valid_ff, s1_valid_in;
   logic signed [P1_W-1:0]   s1_cx_ff, s1_sz_ff, s1_cz_ff, s1_sx_ff;
   logic signed [P1_W-1:0]   s1_cx_in, s1_sz_in, s1_cz_in, s1_sx_in;
   logic signed [HALF_W-1:0] s1_y_ff, s1_y_in;

   // Stage 2: pitch-rotated x and depth.
   logic                     s2_valid_ff, s2_valid_in;
   logic signed [X1_W-1:0]   s2_x1_ff, s2_x1_in;
   z2_type                   s2_z2_ff, s2_z2_in;
   logic signed [HALF_W-1:0] s2_y_ff, s2_y_in;
   logic signed [S1_W-1:0]   x1_sum, z2_sum, x1_biased, z2_biased;

   // Stage 3: yaw products.
   logic                     s3_valid_ff, s3_valid_in;
   logic signed [P2_W-1:0]   s3_cx_ff, s3_sy_ff, s3_sx_ff, s3_cy_ff;
   logic signed [P2_W-1:0]   s3_cx_in, s3_sy_in, s3_sx_in, s3_cy_in;
   z2_type                   s3_z2_ff, s3_z2_in;

   // Stage 4: rotated point.
   rot_type                  rot_ff, rot_in;
   logic signed [P2_W-1:0]   x2_sum, y2_sum, x2_biased, y2_biased;
   logic signed [DIFF_W-1:0] depth_diff;

   // Stage 0 logic.
   always_comb begin
      s0_valid_in = in_valid;
      s0_x_in     = half_coord(pos_x);
      s0_y_in     = half_coord(pos_y);
      s0_z_in     = half_coord(pos_z);
   end

   // Stage 1 logic.
   always_comb begin
      s1_valid_in = s0_valid_ff;
      s1_cx_in    = $signed(cfg.cos_pitch) * s0_x_ff;
      s1_sz_in    = $signed(cfg.sin_pitch) * s0_z_ff;
      s1_cz_in    = $signed(cfg.cos_pitch) * s0_z_ff;
      s1_sx_in    = $signed(cfg.sin_pitch) * s0_x_ff;
      s1_y_in     = s0_y_ff;
   end

   // Stage 2 logic: sums, then divide by 256 and 128 toward zero.
   always_comb begin
      x1_sum      = S1_W'(s1_cx_ff) + S1_W'(s1_sz_ff);
      z2_sum      = S1_W'(s1_cz_ff) - S1_W'(s1_sx_ff);
      x1_biased   = x1_sum + (x1_sum[S1_W-1] ? BIAS1_8 : ZERO1);
      z2_biased   = z2_sum + (z2_sum[S1_W-1] ? BIAS1_7 : ZERO1);
      s2_valid_in = s1_valid_ff;
      s2_x1_in    = X1_W'(x1_biased >>> 8);
      s2_z2_in    = Z2_W'(z2_biased >>> 7);
      s2_y_in     = s1_y_ff;
   end

   // Stage 3 logic.
   always_comb begin
      s3_valid_in = s2_valid_ff;
      s3_cx_in    = $signed(cfg.cos_yaw) * s2_x1_ff;
      s3_sy_in    = $signed(cfg.sin_yaw) * s2_y_ff;
      s3_sx_in    = $signed(cfg.sin_yaw) * s2_x1_ff;
      s3_cy_in    = $signed(cfg.cos_yaw) * s2_y_ff;
      s3_z2_in    = s2_z2_ff;
   end

   // Stage 4 logic: yaw sums divided by 128, visibility and scale index.
   always_comb begin
      x2_sum       = s3_cx_ff - s3_sy_ff;
      y2_sum       = s3_sx_ff + s3_cy_ff;
      x2_biased    = x2_sum + (x2_sum[P2_W-1] ? BIAS2_7 : ZERO2);
      y2_biased    = y2_sum + (y2_sum[P2_W-1] ? BIAS2_7 : ZERO2);
      depth_diff   = DIFF_W'(s3_z2_ff) - DIFF_W'($signed({1'b0, cfg.focal_distance}));
      rot_in.valid = s3_valid_ff;
      rot_in.x2    = X2_W'(x2_biased >>> 7);
      rot_in.y2    = X2_W'(y2_biased >>> 7);
      rot_in.z2    = s3_z2_ff;
      rot_in.visible = ~s3_z2_ff[Z2_W-1] & (|s3_z2_ff);
      priority if (depth_diff[DIFF_W-1]) begin
         rot_in.scale = '0;
      end else if (|depth_diff[DIFF_W-2:SCALE_W+SCALE_SHIFT]) begin
         rot_in.scale = SCALE_MAX;
      end else begin
         rot_in.scale = depth_diff[SCALE_W+SCALE_SHIFT-1:SCALE_SHIFT];
      end
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         rot_ff      <= '0;
      end else begin
         s0_valid_ff <= s0_valid_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         rot_ff      <= rot_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      s0_x_ff  <= s0_x_in;
      s0_y_ff  <= s0_y_in;
      s0_z_ff  <= s0_z_in;
      s1_cx_ff <= s1_cx_in;
      s1_sz_ff <= s1_sz_in;
      s1_cz_ff <= s1_cz_in;
      s1_sx_ff <= s1_sx_in;
      s1_y_ff  <= s1_y_in;
      s2_x1_ff <= s2_x1_in;
      s2_z2_ff <= s2_z2_in;
      s2_y_ff  <= s2_y_in;
      s3_cx_ff <= s3_cx_in;
      s3_sy_ff <= s3_sy_in;
      s3_sx_ff <= s3_sx_in;
      s3_cy_ff <= s3_cy_in;
      s3_z2_ff <= s3_z2_in;
   end

   assign rot = rot_ff;

endmodule

`default_nettype wire

/* src/prp_div.sv */
// ----------------------------------------------------------------------------
// prp_div: pipelined unsigned restoring divider
// Resolves a fixed number of quotient bits per register stage, most
// significant first. A new division can enter in every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module prp_div (
   input  logic                       clock,
   input  logic [prp_pkg::DVD_W-1:0]  dividend,
   input  logic [prp_pkg::DVS_W-1:0]  divisor,
   output logic [prp_pkg::DVD_W-1:0]  quotient
);
   import prp_pkg::*;

   localparam int NUM_W = DIV_STAGES * DIV_BITS;

   typedef struct packed {
      logic [DVS_W-1:0] rem;
      logic [NUM_W-1:0] num;
      logic [NUM_W-1:0] quo;
      logic [DVS_W-1:0] dvs;
   } div_state_type;

   // One stage: shift in the next dividend bits and subtract where it fits.
   function automatic div_state_type div_step(input div_state_type s);
      div_state_type r;
      logic [DVS_W:0] trial;
      r = s;
      for (int i = 0; i < DIV_BITS; i++) begin
         trial = {r.rem, r.num[NUM_W-1]};
         r.num = {r.num[NUM_W-2:0], 1'b0};
         if (trial >= {1'b0, r.dvs}) begin
            trial = trial - {1'b0, r.dvs};
            r.quo = {r.quo[NUM_W-2:0], 1'b1};
         end else begin
            r.quo = {r.quo[NUM_W-2:0], 1'b0};
         end
         r.rem = trial[DVS_W-1:0];
      end
      return r;
   endfunction

   div_state_type first;
   div_state_type stage_in [DIV_STAGES];
   div_state_type stage_ff [DIV_STAGES];

   // Stage chain.
   always_comb begin
      first.rem   = '0;
      first.num   = NUM_W'(dividend);
      first.quo   = '0;
      first.dvs   = divisor;
      stage_in[0] = div_step(first);
      for (int s = 1; s < DIV_STAGES; s++) begin
         stage_in[s] = div_step(stage_ff[s-1]);
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
         stage_ff[s] <= stage_in[s];
      end
   end

   assign quotient = stage_ff[DIV_STAGES-1].quo[DVD_W-1:0];

endmodule

`default_nettype wire

/* src/prp_project.sv */
// ----------------------------------------------------------------------------
// prp_project: perspective projection
// Multiplies the rotated x and y magnitudes by the focal distance, divides
// both by the depth in two pipelined dividers, restores the signs and adds
// the screen center. Hidden points get the fixed off-screen result.
// ----------------------------------------------------------------------------
`default_nettype none

module prp_project (
   input  logic              clock,
   input  logic              reset,
   input  prp_pkg::rot_type  rot,
   input  prp_pkg::cfg_type  cfg,
   output prp_pkg::rsp_type  rsp
);
   import prp_pkg::*;

   // Control that travels beside the dividers.
   typedef struct packed {
      logic      valid;
      logic      neg_x;
      logic      neg_y;
      logic      visible;
      scale_type scale;
   } side_type;

   x2_type            abs_x, abs_y;
   logic [MAG_W-1:0]  mag_x, mag_y;

   side_type          s5_side_ff, s5_side_in;
   logic [DVD_W-1:0]  s5_dvd_x_ff, s5_dvd_y_ff, s5_dvd_x_in, s5_dvd_y_in;
   logic [DVS_W-1:0]  s5_dvs_ff, s5_dvs_in;

   side_type          side_ff [DIV_STAGES];
   side_type          side_in [DIV_STAGES];

   logic [DVD_W-1:0]  quo_x, quo_y;
   logic [COORD_W-1:0] q_x, q_y;
   side_type          last;
   rsp_type           rsp_ff, rsp_in;

   // Stage 5: magnitudes times focal distance; depth as divisor.
   always_comb begin
      abs_x = rot.x2[X2_W-1] ? -rot.x2 : rot.x2;
      abs_y = rot.y2[X2_W-1] ? -rot.y2 : rot.y2;
      mag_x = abs_x[MAG_W-1:0];
      mag_y = abs_y[MAG_W-1:0];
      s5_dvd_x_in        = mag_x * cfg.focal_distance;
      s5_dvd_y_in        = mag_y * cfg.focal_distance;
      s5_dvs_in          = rot.z2[DVS_W-1:0];
      s5_side_in.valid   = rot.valid;
      s5_side_in.neg_x   = rot.x2[X2_W-1];
      s5_side_in.neg_y   = rot.y2[X2_W-1];
      s5_side_in.visible = rot.visible;
      s5_side_in.scale   = rot.scale;
   end

   prp_div u_div_x (
      .clock    (clock),
      .dividend (s5_dvd_x_ff),
      .divisor  (s5_dvs_ff),
      .quotient (quo_x)
   );

   prp_div u_div_y (
      .clock    (clock),
      .dividend (s5_dvd_y_ff),
      .divisor  (s5_dvs_ff),
      .quotient (quo_y)
   );

   // Delay line matching the divider stages.
   always_comb begin
      side_in[0] = s5_side_ff;
      for (int s = 1; s < DIV_STAGES; s++) begin
         side_in[s] = side_ff[s-1];
      end
   end

   // Output stage: only the low bits of the quotient reach the 16-bit result.
   always_comb begin
      last = side_ff[DIV_STAGES-1];
      q_x  = quo_x[COORD_W-1:0];
      q_y  = quo_y[COORD_W-1:0];
      rsp_in.valid = last.valid;
      if (last.visible) begin
         rsp_in.screen_x    = cfg.center_x + (last.neg_x ? -q_x : q_x);
         rsp_in.screen_y    = cfg.center_y + (last.neg_y ? -q_y : q_y);
         rsp_in.visible     = 1'b1;
         rsp_in.depth_scale = last.scale;
      end else begin
         rsp_in.screen_x    = HIDDEN_X;
         rsp_in.screen_y    = '0;
         rsp_in.visible     = 1'b0;
         rsp_in.depth_scale = '0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s5_side_ff <= '0;
         for (int s = 0; s < DIV_STAGES; s++) begin
            side_ff[s] <= '0;
         end
         rsp_ff <= '0;
      end else begin
         s5_side_ff <= s5_side_in;
         for (int s = 0; s < DIV_STAGES; s++) begin
            side_ff[s] <= side_in[s];
         end
         rsp_ff <= rsp_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      s5_dvd_x_ff <= s5_dvd_x_in;
      s5_dvd_y_ff <= s5_dvd_y_in;
      s5_dvs_ff   <= s5_dvs_in;
   end

   assign rsp = rsp_ff;

endmodule

`default_nettype wire

/* src/prp_checker.sv */
// ----------------------------------------------------------------------------
// prp_checker: port-level checks of the point rotate and project block
// Checks result timing against accepted points and the form of results for
// hidden points, and the busy cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module prp_checker (
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic                rsp_valid,
   input prp_pkg::coord_type  rsp_screen_x,
   input prp_pkg::coord_type  rsp_screen_y,
   input logic                rsp_visible,
   input prp_pkg::scale_type  rsp_depth_scale
);
   import prp_pkg::*;

   // Every accepted point produces a result after the fixed latency.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("accepted point produced no result after the pipeline latency");

   // No result appears without a point accepted the latency earlier.
   a_no_stray_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result strobe without a matching accepted point");

   // A hidden point carries the fixed off-screen result.
   a_hidden_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_visible) |->
         (rsp_screen_x == HIDDEN_X && rsp_screen_y == '0 && rsp_depth_scale == '0))
      else $error("hidden point result has unexpected fields");

   // The block holds off points in the first cycle after reset.
   a_busy_after_reset: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> busy)
      else $error("busy not raised after reset");

endmodule

bind point_rotate_project prp_checker u_checker (.*);

`default_nettype wire
